// ----- rtl/lqh_pkg.sv -----
`default_nettype none
package lqh_pkg;

    localparam int KEY_W    = 31;
    localparam int SIZE_W   = 11;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [KEY_W-1:0] key;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [SIZE_W-1:0]   probe_count;
    } result_t;

    // classified command between front and back
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] home;
        logic [SIZE_W-1:0] step;
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/linear_quotient_hash_table.sv -----
// insert and lookup run two restoring divisions in the front end, pass through the
// command queue and then probe slots in the back end; a clear sweeps every slot
// the front end takes a new request only once the previous one has left for the queue;
// the probe walk overlaps the next division
// reset: slot memory is swept after reset, a clear, or a size write while the back end
// is idle or sweeping; full stays high meanwhile; the size register resets to 1021
`default_nettype none
module linear_quotient_hash_table #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire lqh_pkg::request_t          request,
    output logic                            empty,
    input  wire logic                       pop,
    output lqh_pkg::result_t                result,
    input  wire logic                       cfg_we,
    input  wire logic [lqh_pkg::SIZE_W-1:0] cfg_data
);
    import lqh_pkg::*;

    logic [SIZE_W-1:0] size_cfg_reg;
    logic [SIZE_W-1:0] n;
    logic              front_busy;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    cmd_t              q_wdata;
    cmd_t              q_rdata;
    logic              sweeping;
    logic              res_valid;

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_cfg_reg <= cfg_data;
        end
    end

    // size in use, saturated into [2, CAPACITY]
    always_comb
    begin
        if (size_cfg_reg < SIZE_MIN)
        begin
            n = SIZE_MIN;
        end
        else if (32'(size_cfg_reg) > 32'(CAPACITY))
        begin
            n = SIZE_W'(CAPACITY);
        end
        else
        begin
            n = size_cfg_reg;
        end
    end

    assign full  = front_busy || sweeping;
    assign empty = !res_valid;

    lqh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .n       (n),
        .push    (push && !full),
        .request (request),
        .busy    (front_busy),
        .q_push  (q_push),
        .q_data  (q_wdata),
        .q_full  (q_full)
    );

    lqh_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    lqh_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n),
        .cfg_clear (cfg_we),
        .q_data    (q_rdata),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .sweeping  (sweeping),
        .res_valid (res_valid),
        .result    (result),
        .res_pop   (pop)
    );

    // no request is taken while the slot memory is being swept
    assert property (@(posedge clk) disable iff (!rst_n) sweeping |-> full)
        else $error("request accepted during clearing pass");

    // table full carries no slot and no probe count
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == ST_FULL) |-> (result.slot_index == '0 &&
        result.probe_count == '0))
        else $error("full result with nonzero fields");

    // a hit or an insert always examined at least one slot within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.status == ST_FOUND || result.status == ST_INSERTED)) |->
        (result.probe_count != '0 && result.probe_count <= n))
        else $error("probe count out of range");

    // result codes stay within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.status <= ST_CLEARED))
        else $error("undefined result status");

endmodule
`default_nettype wire

// ----- rtl/lqh_ram.sv -----
`default_nettype none
module lqh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ----- rtl/lqh_queue.sv -----
`default_nettype none
module lqh_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lqh_pkg::cmd_t wdata,
    output logic               full,
    input  wire logic          pop,
    output lqh_pkg::cmd_t      rdata,
    output logic               empty
);
    import lqh_pkg::*;

    cmd_t       data_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rdata   = data_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // two entry command buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                data_reg[wptr_reg] <= wdata;
                wptr_reg           <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lqh_front.sv -----
`default_nettype none
module lqh_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lqh_pkg::SIZE_W-1:0] n,
    input  wire logic                       push,
    input  wire lqh_pkg::request_t          request,
    output logic                            busy,
    output logic                            q_push,
    output lqh_pkg::cmd_t                   q_data,
    input  wire logic                       q_full
);
    import lqh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV1, S_DIV2, S_PUSH} state_t;

    localparam logic [4:0] DIV_LAST = 5'(KEY_W - 1);

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [KEY_W-1:0]  qd_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [4:0]        cnt_reg;
    logic [SIZE_W:0]   rem_sh;
    logic              ge;
    logic [SIZE_W:0]   rem_diff;
    logic [SIZE_W-1:0] rem_new;
    logic [KEY_W-1:0]  qd_new;

    // one restoring division step per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, qd_reg[KEY_W-1]};
        ge       = (rem_sh >= {1'b0, n});
        rem_diff = rem_sh - {1'b0, n};
        rem_new  = ge ? rem_diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
        qd_new   = {qd_reg[KEY_W-2:0], ge};
    end

    assign busy   = (state_reg != S_IDLE);
    assign q_push = (state_reg == S_PUSH);
    assign q_data = cmd_reg;

    // home = key mod n, then step = (key div n) mod n, with a zero step forced to 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (push)
                    begin
                        cmd_reg.opcode <= request.opcode;
                        cmd_reg.key    <= request.key;
                        cmd_reg.home   <= '0;
                        cmd_reg.step   <= '0;
                        qd_reg         <= request.key;
                        rem_reg        <= '0;
                        cnt_reg        <= '0;
                        if (request.opcode == OP_INSERT || request.opcode == OP_LOOKUP)
                        begin
                            state_reg <= S_DIV1;
                        end
                        else
                        begin
                            state_reg <= S_PUSH;
                        end
                    end
                end
                S_DIV1:
                begin
                    if (cnt_reg == DIV_LAST)
                    begin
                        cmd_reg.home <= rem_new;
                        qd_reg       <= qd_new;
                        rem_reg      <= '0;
                        cnt_reg      <= '0;
                        state_reg    <= S_DIV2;
                    end
                    else
                    begin
                        qd_reg  <= qd_new;
                        rem_reg <= rem_new;
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_DIV2:
                begin
                    if (cnt_reg == DIV_LAST)
                    begin
                        cmd_reg.step <= (rem_new == '0) ? SIZE_W'(1) : rem_new;
                        state_reg    <= S_PUSH;
                    end
                    else
                    begin
                        qd_reg  <= qd_new;
                        rem_reg <= rem_new;
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lqh_back.sv -----
`default_nettype none
module lqh_back #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lqh_pkg::SIZE_W-1:0] n,
    input  wire logic                       cfg_clear,
    input  wire lqh_pkg::cmd_t              q_data,
    input  wire logic                       q_empty,
    output logic                            q_pop,
    output logic                            sweeping,
    output logic                            res_valid,
    output lqh_pkg::result_t                result,
    input  wire logic                       res_pop
);
    import lqh_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] LAST_ADDR = IW'(CAPACITY - 1);

    typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_READ, S_CHECK} state_t;

    state_t            state_reg;
    logic [IW-1:0]     swp_reg;
    logic              clr_pend_reg;
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SIZE_W-1:0] step_reg;
    logic [SIZE_W-1:0] idx_reg;
    logic [SIZE_W-1:0] probes_reg;
    logic [SIZE_W-1:0] occ_reg;
    logic              res_valid_reg;
    result_t           res_reg;

    logic                 ram_we;
    logic [IW-1:0]        ram_addr;
    logic [KEY_W:0]       ram_wdata;
    logic [KEY_W:0]       ram_rdata;
    logic [IW+SIZE_W-1:0] idx_ext;
    logic                 slot_used;
    logic                 key_hit;
    logic [SIZE_W:0]      adv_sum;
    logic [SIZE_W:0]      adv_diff;
    logic [SIZE_W-1:0]    idx_adv;
    logic                 last_probe;

    assign sweeping  = (state_reg == S_SWEEP);
    assign res_valid = res_valid_reg;
    assign result    = res_reg;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty && !res_valid_reg && !cfg_clear;

    // slot address, next probe position and hit checks
    always_comb
    begin
        idx_ext    = {{IW{1'b0}}, idx_reg};
        slot_used  = ram_rdata[KEY_W];
        key_hit    = slot_used && (ram_rdata[KEY_W-1:0] == key_reg);
        adv_sum    = {1'b0, idx_reg} + {1'b0, step_reg};
        adv_diff   = adv_sum - {1'b0, n};
        idx_adv    = (adv_sum >= {1'b0, n}) ? adv_diff[SIZE_W-1:0] : adv_sum[SIZE_W-1:0];
        last_probe = (probes_reg == n);
        ram_we     = 1'b0;
        ram_addr   = idx_ext[IW-1:0];
        ram_wdata  = {1'b1, key_reg};
        if (state_reg == S_SWEEP)
        begin
            ram_we    = 1'b1;
            ram_addr  = swp_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_CHECK && op_reg == OP_INSERT && !slot_used)
        begin
            ram_we = 1'b1;
        end
    end

    lqh_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // probe sequencer, clearing pass and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            swp_reg       <= '0;
            clr_pend_reg  <= 1'b0;
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_SWEEP:
                begin
                    if (cfg_clear)
                    begin
                        swp_reg <= '0;
                    end
                    else if (swp_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                        if (clr_pend_reg)
                        begin
                            clr_pend_reg          <= 1'b0;
                            res_valid_reg         <= 1'b1;
                            res_reg.status        <= ST_CLEARED;
                            res_reg.slot_index    <= '0;
                            res_reg.probe_count   <= '0;
                        end
                    end
                    else
                    begin
                        swp_reg <= swp_reg + IW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (cfg_clear)
                    begin
                        occ_reg   <= '0;
                        swp_reg   <= '0;
                        state_reg <= S_SWEEP;
                    end
                    else if (q_pop)
                    begin
                        op_reg     <= q_data.opcode;
                        key_reg    <= q_data.key;
                        step_reg   <= q_data.step;
                        idx_reg    <= q_data.home;
                        probes_reg <= SIZE_W'(1);
                        if (q_data.opcode == OP_INSERT || q_data.opcode == OP_LOOKUP)
                        begin
                            state_reg <= S_READ;
                        end
                        else if (q_data.opcode == OP_CLEAR)
                        begin
                            occ_reg      <= '0;
                            swp_reg      <= '0;
                            clr_pend_reg <= 1'b1;
                            state_reg    <= S_SWEEP;
                        end
                        else
                        begin
                            res_valid_reg       <= 1'b1;
                            res_reg.status      <= ST_MISSING;
                            res_reg.slot_index  <= '0;
                            res_reg.probe_count <= '0;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    state_reg <= S_IDLE;
                    if (op_reg == OP_INSERT)
                    begin
                        if (!slot_used)
                        begin
                            occ_reg             <= occ_reg + SIZE_W'(1);
                            res_valid_reg       <= 1'b1;
                            res_reg.status      <= ST_INSERTED;
                            res_reg.slot_index  <= idx_reg[SLOT_W-1:0];
                            res_reg.probe_count <= probes_reg;
                        end
                        else if (last_probe || (probes_reg == SIZE_W'(1) && occ_reg >= n))
                        begin
                            res_valid_reg       <= 1'b1;
                            res_reg.status      <= ST_FULL;
                            res_reg.slot_index  <= '0;
                            res_reg.probe_count <= '0;
                        end
                        else
                        begin
                            idx_reg    <= idx_adv;
                            probes_reg <= probes_reg + SIZE_W'(1);
                            state_reg  <= S_READ;
                        end
                    end
                    else
                    begin
                        if (key_hit)
                        begin
                            res_valid_reg       <= 1'b1;
                            res_reg.status      <= ST_FOUND;
                            res_reg.slot_index  <= idx_reg[SLOT_W-1:0];
                            res_reg.probe_count <= probes_reg;
                        end
                        else if (last_probe)
                        begin
                            res_valid_reg       <= 1'b1;
                            res_reg.status      <= ST_MISSING;
                            res_reg.slot_index  <= '0;
                            res_reg.probe_count <= n;
                        end
                        else
                        begin
                            idx_reg    <= idx_adv;
                            probes_reg <= probes_reg + SIZE_W'(1);
                            state_reg  <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import lqh_pkg::*;

    localparam int CAP = 1024;
    localparam int LIMIT = 4_000_000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX = 31'h7fff_ffff;

    // hash table predictor and store of expected results
    class table_scoreboard;
        bit [KEY_W-1:0] keys [CAP];
        bit             used [CAP];
        int unsigned    occupied;
        int unsigned    n;
        result_t        expected_q [$];
        int             errors;

        function void set_size(logic [SIZE_W-1:0] v);
            n = v;
            if (n < 2) n = 2;
            if (n > CAP) n = CAP;
            foreach (used[i]) used[i] = 0;
            occupied = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // note an accepted request and work out its result
        function void note_request(request_t r);
            result_t e;
            int unsigned k, home, stp, idx, p;
            bit done;
            k = r.key;
            home = k % n;
            stp = k / n;
            if (stp == 0 || stp % n == 0) stp = 1;
            stp = stp % n;
            idx = home;
            done = 0;
            e.status = ST_MISSING;
            e.slot_index = '0;
            e.probe_count = '0;
            case (r.opcode)
                OP_INSERT:
                begin
                    e.status = ST_FULL;
                    if (!used[home]) begin
                        keys[home] = r.key;
                        used[home] = 1;
                        occupied++;
                        e.status = ST_INSERTED;
                        e.slot_index = SLOT_W'(home);
                        e.probe_count = SIZE_W'(1);
                    end else if (occupied < n) begin
                        for (p = 2; p <= n && !done; p++) begin
                            idx = (idx + stp) % n;
                            if (!used[idx]) begin
                                keys[idx] = r.key;
                                used[idx] = 1;
                                occupied++;
                                e.status = ST_INSERTED;
                                e.slot_index = SLOT_W'(idx);
                                e.probe_count = SIZE_W'(p);
                                done = 1;
                            end
                        end
                    end
                end
                OP_LOOKUP:
                begin
                    e.probe_count = SIZE_W'(n);
                    for (p = 1; p <= n && !done; p++) begin
                        if (used[idx] && keys[idx] == r.key) begin
                            e.status = ST_FOUND;
                            e.slot_index = SLOT_W'(idx);
                            e.probe_count = SIZE_W'(p);
                            done = 1;
                        end
                        idx = (idx + stp) % n;
                    end
                end
                OP_CLEAR:
                begin
                    foreach (used[i]) used[i] = 0;
                    occupied = 0;
                    e.status = ST_CLEARED;
                end
                default: ;
            endcase
            expected_q.push_back(e);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(result_t a);
            result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d probes=%0d",
                         $time, a.status, a.slot_index, a.probe_count);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
                errors++;
            end
            if (a.slot_index !== e.slot_index) begin
                $display("%0t: slot_index expected %0d actual %0d",
                         $time, e.slot_index, a.slot_index);
                errors++;
            end
            if (a.probe_count !== e.probe_count) begin
                $display("%0t: probe_count expected %0d actual %0d",
                         $time, e.probe_count, a.probe_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    request_t request;
    logic empty;
    logic pop;
    result_t result;
    logic cfg_we;
    logic [SIZE_W-1:0] cfg_data;

    table_scoreboard sb;
    logic [KEY_W-1:0] stored_keys [$];
    int accepted_results;
    int hold_cycles;
    int cycle_count;

    linear_quotient_hash_table #(.CAPACITY(CAP)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 80);
    endfunction

    // result side: check accepted results, start long holds
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty) begin
            sb.check_result(result);
            accepted_results++;
            if (accepted_results == 100 || accepted_results == 400)
                hold_cycles = 3000;
        end
    end

    // pop driver with random stalls
    initial
    begin
        int g;
        pop = 0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                pop = 0;
                hold_cycles--;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    pop = 1;
                end else begin
                    pop = 0;
                    repeat (g - 1) @(negedge clk);
                    pop = 1;
                end
            end
        end
    end

    // offer one request and hold it until accepted
    task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
        request_t r;
        int g;
        r.opcode = op;
        r.key = k;
        @(negedge clk);
        push = 1;
        request = r;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_request(r);
        if (op == OP_INSERT) stored_keys.push_back(k);
        if (op == OP_CLEAR) stored_keys.delete();
        g = gap_len();
        if (g > 0) begin
            @(negedge clk);
            push = 0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        push = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // table size write while the block is idle
    task automatic write_size(input logic [SIZE_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_we = 1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 0;
        cfg_data = SIZE_W'($urandom);
        sb.set_size(v);
        stored_keys.delete();
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int unsigned n);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && stored_keys.size() > 0)
            return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        if (r < 6) return KEY_W'($urandom_range(0, 4 * n));
        if (r == 6) return KEY_W'(n * n * $urandom_range(1, 50) + $urandom_range(0, n - 1));
        if (r == 7) return KEY_MAX - KEY_W'($urandom_range(0, 100));
        return KEY_W'($urandom) & KEY_MAX;
    endfunction

    // random requests at the current size
    task automatic run_phase(input int count);
        int r;
        logic [OP_W-1:0] op;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && count > 60) drain();
            r = $urandom_range(0, 99);
            if (r < 48) op = OP_INSERT;
            else if (r < 92) op = OP_LOOKUP;
            else if (r < 96) op = OP_CLEAR;
            else op = OP_UNUSED;
            // keep slow lookup misses rare on big tables
            if (op == OP_LOOKUP && sb.n > 64 && stored_keys.size() > 0
                && $urandom_range(0, 3) != 0)
                send(op, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            else
                send(op, pick_key(sb.n));
        end
    endtask

    initial
    begin
        sb = new();
        sb.set_size(SIZE_RESET);
        accepted_results = 0;
        hold_cycles = 0;
        push = 0;
        request = '0;
        cfg_we = 0;
        cfg_data = '0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, forced step, duplicates, miss, unused opcode, clear
        send(OP_INSERT, 31'd0);
        send(OP_INSERT, KEY_MAX);
        send(OP_INSERT, 31'd5);
        send(OP_INSERT, 31'd1042446);
        send(OP_INSERT, 31'd5);
        send(OP_LOOKUP, 31'd1042446);
        send(OP_LOOKUP, 31'd5);
        send(OP_LOOKUP, KEY_MAX);
        send(OP_LOOKUP, 31'd0);
        send(OP_LOOKUP, 31'd12345);
        send(OP_UNUSED, KEY_MAX);
        send(OP_CLEAR, 31'd0);
        send(OP_LOOKUP, 31'd5);
        send(OP_INSERT, 31'd1);
        run_phase(30);

        write_size(11'd0);
        send(OP_INSERT, 31'd0);
        send(OP_INSERT, 31'd2);
        send(OP_INSERT, 31'd4);
        send(OP_LOOKUP, 31'd4);
        run_phase(60);
        write_size(11'd7);
        run_phase(90);
        write_size(11'd12);
        run_phase(90);
        write_size(11'd2047);
        run_phase(35);
        write_size(11'd13);
        run_phase(90);
        write_size(11'd1);
        run_phase(40);
        write_size(11'd1024);
        run_phase(35);
        write_size(11'd4);
        run_phase(80);

        // wait for the last results, then let the block settle
        @(negedge clk);
        push = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2 * CAP + 100) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
